/* hdl/rprop_pkg.sv */
`default_nettype none

package rprop_pkg;

   localparam int INDEX_WIDTH     = 10;
   localparam int DATA_WIDTH      = 32;
   localparam int STEP_WIDTH      = 31;
   localparam int ETA_WIDTH       = 18;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;
   localparam int PROD_WIDTH      = STEP_WIDTH + ETA_WIDTH;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ETA_INCREASE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ETA_DECREASE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_MAX     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_MIN     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_STEP = 3'd4;

   localparam logic [ETA_WIDTH-1:0]  ETA_INCREASE_RESET = 18'd78643;
   localparam logic [ETA_WIDTH-1:0]  ETA_DECREASE_RESET = 18'd32768;
   localparam logic [STEP_WIDTH-1:0] STEP_MAX_RESET     = 31'd838860800;
   localparam logic [STEP_WIDTH-1:0] STEP_MIN_RESET     = 31'd17;
   localparam logic [STEP_WIDTH-1:0] INITIAL_STEP_RESET = 31'd1677722;
   localparam logic [STEP_WIDTH-1:0] STEP_LIMIT         = 31'h7FFF_FFFF;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   localparam logic [1:0] BR_LOAD  = 2'd0;
   localparam logic [1:0] BR_SAME  = 2'd1;
   localparam logic [1:0] BR_FLIP  = 2'd2;
   localparam logic [1:0] BR_FRESH = 2'd3;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] weight;
      logic [STEP_WIDTH-1:0] step;
      logic [1:0]            sign;
      logic [DATA_WIDTH-1:0] corr;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/rprop_if.sv */
`default_nettype none

interface rprop_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [rprop_pkg::INDEX_WIDTH-1:0]   weight_index;
   logic signed [rprop_pkg::DATA_WIDTH-1:0] value;

   modport source (output valid, action, weight_index, value, input ready);
   modport sink   (input valid, action, weight_index, value, output ready);
endinterface

interface rprop_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rprop_pkg::INDEX_WIDTH-1:0]   result_index;
   logic signed [rprop_pkg::DATA_WIDTH-1:0] weight_value;
   logic [1:0]                          branch_taken;
   logic                                saturated;

   modport source (output valid, result_index, weight_value, branch_taken, saturated,
                   input ready);
   modport sink   (input valid, result_index, weight_value, branch_taken, saturated,
                   output ready);
endinterface

`default_nettype wire

/* hdl/rprop_weight_update_core.sv */
// The request word is taken with the table read; then come the 31x18 step
// multiply and write-back of the single-port entry table with the result
// registered. A new request word is taken only after the last write-back.
// A finished result may wait at the output while the next request is taken.
// Reset (synchronous, active high) idles the controller, drops rsp valid and
// restores register defaults; table entries are undefined until loaded.
`default_nettype none

module rprop_weight_update_core #(
   parameter int WEIGHT_COUNT = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rprop_req_if.sink                             req_bus,
   rprop_rsp_if.source                           rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [rprop_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rprop_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   rprop_pkg::cmd_type cmd;
   logic               req_ready;
   logic               rsp_valid;

   rprop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   rprop_dpath #(
      .WEIGHT_COUNT (WEIGHT_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_action       (req_bus.action),
      .req_weight_index (req_bus.weight_index),
      .req_value        (req_bus.value),
      .rsp_result_index (rsp_bus.result_index),
      .rsp_weight_value (rsp_bus.weight_value),
      .rsp_branch_taken (rsp_bus.branch_taken),
      .rsp_saturated    (rsp_bus.saturated)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

`default_nettype wire

/* hdl/rprop_ctrl.sv */
`default_nettype none

module rprop_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rprop_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            // hold the finished word until the output register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/rprop_dpath.sv */
`default_nettype none

module rprop_dpath #(
   parameter int WEIGHT_COUNT = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rprop_pkg::cmd_type                       cmd,
   input  logic                                     csr_write_enable,
   input  logic [rprop_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rprop_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                                     req_action,
   input  logic [rprop_pkg::INDEX_WIDTH-1:0]        req_weight_index,
   input  logic [rprop_pkg::DATA_WIDTH-1:0]         req_value,
   output logic [rprop_pkg::INDEX_WIDTH-1:0]        rsp_result_index,
   output logic [rprop_pkg::DATA_WIDTH-1:0]         rsp_weight_value,
   output logic [1:0]                               rsp_branch_taken,
   output logic                                     rsp_saturated
);

   localparam int AddrW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
   localparam int DW    = rprop_pkg::DATA_WIDTH;
   localparam int SW    = rprop_pkg::STEP_WIDTH;
   localparam int EW    = rprop_pkg::ETA_WIDTH;
   localparam int PW    = rprop_pkg::PROD_WIDTH;
   localparam int IW    = rprop_pkg::INDEX_WIDTH;

   // configuration registers
   logic [EW-1:0] eta_inc_ff, eta_dec_ff;
   logic [SW-1:0] step_max_ff, step_min_ff, init_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_inc_ff   <= rprop_pkg::ETA_INCREASE_RESET;
         eta_dec_ff   <= rprop_pkg::ETA_DECREASE_RESET;
         step_max_ff  <= rprop_pkg::STEP_MAX_RESET;
         step_min_ff  <= rprop_pkg::STEP_MIN_RESET;
         init_step_ff <= rprop_pkg::INITIAL_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rprop_pkg::CSR_ETA_INCREASE: eta_inc_ff   <= csr_write_data[EW-1:0];
            rprop_pkg::CSR_ETA_DECREASE: eta_dec_ff   <= csr_write_data[EW-1:0];
            rprop_pkg::CSR_STEP_MAX:     step_max_ff  <= csr_write_data[SW-1:0];
            rprop_pkg::CSR_STEP_MIN:     step_min_ff  <= csr_write_data[SW-1:0];
            rprop_pkg::CSR_INITIAL_STEP: init_step_ff <= csr_write_data[SW-1:0];
            default: begin
            end
         endcase
      end
   end

   // entry table, one word per weight
   rprop_pkg::entry_type entry_mem [WEIGHT_COUNT];
   rprop_pkg::entry_type rd_ff;
   rprop_pkg::entry_type new_entry;

   logic              action_ff;
   logic [IW-1:0]     index_ff;
   logic [DW-1:0]     value_ff;
   logic [AddrW-1:0]  addr_ff;
   logic              in_range_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= req_action;
         index_ff    <= req_weight_index;
         value_ff    <= req_value;
         addr_ff     <= AddrW'(req_weight_index);
         in_range_ff <= ({22'd0, req_weight_index} < 32'(WEIGHT_COUNT));
         rd_ff       <= entry_mem[AddrW'(req_weight_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && in_range_ff) begin
         entry_mem[addr_ff] <= new_entry;
      end
   end

   // sign decode and branch choice
   logic [1:0]    cur_sign, old_sign, branch;
   logic          sign_same, sign_flip;
   logic [EW-1:0] eta_sel;

   always_comb begin
      if (value_ff == '0) begin
         cur_sign = rprop_pkg::SIGN_ZERO;
      end else if (value_ff[DW-1]) begin
         cur_sign = rprop_pkg::SIGN_NEG;
      end else begin
         cur_sign = rprop_pkg::SIGN_POS;
      end
      // the unused code reads as no sign
      if (rd_ff.sign == rprop_pkg::SIGN_POS || rd_ff.sign == rprop_pkg::SIGN_NEG) begin
         old_sign = rd_ff.sign;
      end else begin
         old_sign = rprop_pkg::SIGN_ZERO;
      end
      sign_same = (cur_sign != rprop_pkg::SIGN_ZERO) && (old_sign != rprop_pkg::SIGN_ZERO)
                  && (cur_sign == old_sign);
      sign_flip = (cur_sign != rprop_pkg::SIGN_ZERO) && (old_sign != rprop_pkg::SIGN_ZERO)
                  && (cur_sign != old_sign);
      if (action_ff == rprop_pkg::ACT_LOAD) begin
         branch = rprop_pkg::BR_LOAD;
      end else if (sign_same) begin
         branch = rprop_pkg::BR_SAME;
      end else if (sign_flip) begin
         branch = rprop_pkg::BR_FLIP;
      end else begin
         branch = rprop_pkg::BR_FRESH;
      end
      eta_sel = sign_same ? eta_inc_ff : eta_dec_ff;
   end

   logic [PW-1:0] prod_ff;
   logic [1:0]    branch_ff, cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         prod_ff   <= PW'(rd_ff.step) * PW'(eta_sel);
         branch_ff <= branch;
         cur_ff    <= cur_sign;
      end
   end

   // step clamp, correction and saturating weight add
   logic [PW-17:0] scaled;
   logic [SW-1:0]  scaled_sat, grown, shrunk;
   logic [DW:0]    corr;
   logic [DW+1:0]  sum;
   logic [DW-1:0]  new_weight;
   logic           sat;

   always_comb begin
      scaled     = prod_ff[PW-1:16];
      scaled_sat = (|scaled[PW-17:SW]) ? rprop_pkg::STEP_LIMIT : scaled[SW-1:0];
      grown      = (scaled_sat > step_max_ff) ? step_max_ff : scaled_sat;
      shrunk     = (scaled_sat < step_min_ff) ? step_min_ff : scaled_sat;

      new_entry.step = rd_ff.step;
      new_entry.sign = cur_ff;
      corr           = '0;
      case (branch_ff)
         rprop_pkg::BR_SAME: begin
            new_entry.step = grown;
            corr = (cur_ff == rprop_pkg::SIGN_POS) ? -{2'b00, grown} : {2'b00, grown};
         end
         rprop_pkg::BR_FLIP: begin
            new_entry.step = shrunk;
            new_entry.sign = rprop_pkg::SIGN_ZERO;
            corr = -{rd_ff.corr[DW-1], rd_ff.corr};
         end
         rprop_pkg::BR_FRESH: begin
            if (cur_ff == rprop_pkg::SIGN_POS) begin
               corr = -{2'b00, rd_ff.step};
            end else if (cur_ff == rprop_pkg::SIGN_NEG) begin
               corr = {2'b00, rd_ff.step};
            end
         end
         default: begin
            new_entry.step = init_step_ff;
            new_entry.sign = rprop_pkg::SIGN_ZERO;
         end
      endcase

      sum = {{2{rd_ff.weight[DW-1]}}, rd_ff.weight} + {corr[DW], corr};
      sat = 1'b0;
      if (!sum[DW+1] && (sum[DW:DW-1] != 2'b00)) begin
         new_weight = {1'b0, {(DW-1){1'b1}}};
         sat        = 1'b1;
      end else if (sum[DW+1] && (sum[DW:DW-1] != 2'b11)) begin
         new_weight = {1'b1, {(DW-1){1'b0}}};
         sat        = 1'b1;
      end else begin
         new_weight = sum[DW-1:0];
      end

      if (branch_ff == rprop_pkg::BR_LOAD) begin
         new_weight = value_ff;
         sat        = 1'b0;
      end
      new_entry.weight = new_weight;
      new_entry.corr   = corr[DW-1:0];
   end

   // output register
   logic [IW-1:0] rsp_index_ff;
   logic [DW-1:0] rsp_weight_ff;
   logic [1:0]    rsp_branch_ff;
   logic          rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_index_ff <= index_ff;
         if (in_range_ff) begin
            rsp_weight_ff <= new_weight;
            rsp_branch_ff <= branch_ff;
            rsp_sat_ff    <= sat;
         end else begin
            rsp_weight_ff <= '0;
            rsp_branch_ff <= rprop_pkg::BR_LOAD;
            rsp_sat_ff    <= 1'b0;
         end
      end
   end

   assign rsp_result_index = rsp_index_ff;
   assign rsp_weight_value = rsp_weight_ff;
   assign rsp_branch_taken = rsp_branch_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

`default_nettype wire

/* hdl/rprop_checker.sv */
`default_nettype none

module rprop_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [rprop_pkg::INDEX_WIDTH-1:0]   rsp_result_index,
   input  logic [rprop_pkg::DATA_WIDTH-1:0]    rsp_weight_value,
   input  logic [1:0]                          rsp_branch_taken,
   input  logic                                rsp_saturated
);

   // a waiting result word keeps its payload
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_index)
         && $stable(rsp_weight_value) && $stable(rsp_branch_taken)
         && $stable(rsp_saturated);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp payload changed while stalled");

   // one word in flight: no request taken right after one was taken
   property p_one_in_flight;
      @(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready;
   endproperty
   a_one_in_flight: assert property (p_one_in_flight)
      else $error("request taken while previous word still in work");

   // loads and out-of-range words never report clipping
   property p_load_no_sat;
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken == rprop_pkg::BR_LOAD |-> !rsp_saturated;
   endproperty
   a_load_no_sat: assert property (p_load_no_sat) else $error("load reported saturation");

   // no result word straight out of reset
   property p_reset_quiet;
      @(posedge clock)
      $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_quiet: assert property (p_reset_quiet) else $error("rsp valid after reset");

endmodule

bind rprop_weight_update_core rprop_checker u_rprop_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_index (rsp_bus.result_index),
   .rsp_weight_value (rsp_bus.weight_value),
   .rsp_branch_taken (rsp_bus.branch_taken),
   .rsp_saturated    (rsp_bus.saturated)
);

`default_nettype wire

/* verif/rprop_weight_update_checker.sv */
module rprop_weight_update_checker #(
   parameter int WEIGHT_COUNT = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rprop_req_if                                  req_bus,
   rprop_rsp_if                                  rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [rprop_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rprop_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = rprop_pkg::DATA_WIDTH;
   localparam int IW = rprop_pkg::INDEX_WIDTH;
   localparam int SW = rprop_pkg::STEP_WIDTH;
   localparam int EW = rprop_pkg::ETA_WIDTH;
   localparam int PW = rprop_pkg::PROD_WIDTH;

   localparam longint WEIGHT_MAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;

   typedef struct packed {
      logic [IW-1:0] index;
      logic [DW-1:0] weight;
      logic [1:0]    branch;
      logic          saturated;
   } weight_word_type;

   logic [EW-1:0] eta_inc;
   logic [EW-1:0] eta_dec;
   logic [SW-1:0] step_max;
   logic [SW-1:0] step_min;
   logic [SW-1:0] init_step;

   // shadow of the entry table
   longint     weight_mirror [WEIGHT_COUNT];
   longint     step_mirror   [WEIGHT_COUNT];
   longint     corr_mirror   [WEIGHT_COUNT];
   logic [1:0] sign_mirror   [WEIGHT_COUNT];

   weight_word_type weights_due [$];

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      fail_count++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // step times Q2.16 factor, truncated, capped at the step limit
   function automatic logic [SW-1:0] scale_step(input logic [SW-1:0] step,
                                                input logic [EW-1:0] eta);
      logic [PW-1:0] prod;
      logic [PW-1:0] scaled;
      prod = PW'(step) * PW'(eta);
      scaled = prod >> 16;
      if (scaled > PW'(rprop_pkg::STEP_LIMIT))
         return rprop_pkg::STEP_LIMIT;
      return scaled[SW-1:0];
   endfunction

   function automatic weight_word_type predict_weight(input logic act,
                                                      input logic [IW-1:0] idx,
                                                      input logic signed [DW-1:0] val);
      weight_word_type res;
      longint          grad;
      longint          step;
      longint          corr;
      longint          sum;
      logic [1:0]      old_sign;
      logic [1:0]      cur_sign;
      logic [SW-1:0]   new_step;
      res = '0;
      res.index = idx;
      grad = longint'(val);
      if (int'(idx) < WEIGHT_COUNT) begin
         if (act == rprop_pkg::ACT_LOAD) begin
            weight_mirror[idx] = grad;
            step_mirror[idx] = longint'(init_step);
            sign_mirror[idx] = rprop_pkg::SIGN_ZERO;
            corr_mirror[idx] = 0;
            res.weight = val;
            res.branch = rprop_pkg::BR_LOAD;
         end else begin
            cur_sign = (grad > 0) ? rprop_pkg::SIGN_POS :
                       ((grad < 0) ? rprop_pkg::SIGN_NEG : rprop_pkg::SIGN_ZERO);
            old_sign = sign_mirror[idx];
            if (old_sign == 2'd3)
               old_sign = rprop_pkg::SIGN_ZERO;
            step = step_mirror[idx];
            if (cur_sign != rprop_pkg::SIGN_ZERO && old_sign != rprop_pkg::SIGN_ZERO
                && cur_sign == old_sign) begin
               new_step = scale_step(step[SW-1:0], eta_inc);
               if (new_step > step_max)
                  new_step = step_max;
               step = longint'(new_step);
               corr = (cur_sign == rprop_pkg::SIGN_POS) ? -step : step;
               step_mirror[idx] = step;
               sign_mirror[idx] = cur_sign;
               res.branch = rprop_pkg::BR_SAME;
            end else if (cur_sign != rprop_pkg::SIGN_ZERO
                         && old_sign != rprop_pkg::SIGN_ZERO) begin
               // sign flip: back out the last move, shrink and forget the sign
               new_step = scale_step(step[SW-1:0], eta_dec);
               if (new_step < step_min)
                  new_step = step_min;
               corr = -corr_mirror[idx];
               step_mirror[idx] = longint'(new_step);
               sign_mirror[idx] = rprop_pkg::SIGN_ZERO;
               res.branch = rprop_pkg::BR_FLIP;
            end else begin
               if (cur_sign == rprop_pkg::SIGN_ZERO)
                  corr = 0;
               else
                  corr = (cur_sign == rprop_pkg::SIGN_POS) ? -step : step;
               sign_mirror[idx] = cur_sign;
               res.branch = rprop_pkg::BR_FRESH;
            end
            corr_mirror[idx] = corr;
            sum = weight_mirror[idx] + corr;
            if (sum > WEIGHT_MAX) begin
               sum = WEIGHT_MAX;
               res.saturated = 1'b1;
            end else if (sum < WEIGHT_MIN) begin
               sum = WEIGHT_MIN;
               res.saturated = 1'b1;
            end
            weight_mirror[idx] = sum;
            res.weight = sum[DW-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      weight_word_type due;
      if (reset) begin
         eta_inc <= rprop_pkg::ETA_INCREASE_RESET;
         eta_dec <= rprop_pkg::ETA_DECREASE_RESET;
         step_max <= rprop_pkg::STEP_MAX_RESET;
         step_min <= rprop_pkg::STEP_MIN_RESET;
         init_step <= rprop_pkg::INITIAL_STEP_RESET;
         weights_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rprop_pkg::CSR_ETA_INCREASE: eta_inc <= csr_write_data[EW-1:0];
               rprop_pkg::CSR_ETA_DECREASE: eta_dec <= csr_write_data[EW-1:0];
               rprop_pkg::CSR_STEP_MAX:     step_max <= csr_write_data[SW-1:0];
               rprop_pkg::CSR_STEP_MIN:     step_min <= csr_write_data[SW-1:0];
               rprop_pkg::CSR_INITIAL_STEP: init_step <= csr_write_data[SW-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (weights_due.size() == 0) begin
               report_mismatch("result word with nothing due, index",
                               DW'(rsp_bus.result_index), 'x);
            end else begin
               due = weights_due.pop_front();
               if (rsp_bus.result_index !== due.index)
                  report_mismatch("result_index", DW'(rsp_bus.result_index),
                                  DW'(due.index));
               if (rsp_bus.weight_value !== due.weight)
                  report_mismatch("weight_value", rsp_bus.weight_value, due.weight);
               if (rsp_bus.branch_taken !== due.branch)
                  report_mismatch("branch_taken", DW'(rsp_bus.branch_taken),
                                  DW'(due.branch));
               if (rsp_bus.saturated !== due.saturated)
                  report_mismatch("saturated", DW'(rsp_bus.saturated),
                                  DW'(due.saturated));
            end
         end
         if (req_bus.valid && req_bus.ready)
            weights_due.push_back(predict_weight(req_bus.action, req_bus.weight_index,
                                                 req_bus.value));
      end
      pending <= weights_due.size();
   end

endmodule

/* verif/rprop_weight_update_core_test.sv */
module rprop_weight_update_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW  = rprop_pkg::DATA_WIDTH;
   localparam int IW  = rprop_pkg::INDEX_WIDTH;
   localparam int EW  = rprop_pkg::ETA_WIDTH;
   localparam int CIW = rprop_pkg::CSR_INDEX_WIDTH;
   localparam int CDW = rprop_pkg::CSR_DATA_WIDTH;

   localparam int WEIGHT_COUNT = 1024;
   localparam int HOT_COUNT = 12;
   localparam int PHASE_COUNT = 6;
   localparam int WORDS_PER_PHASE = 150;
   localparam int QUIET_LIMIT = 2000;

   logic clock;
   logic reset;
   logic           csr_write_enable;
   logic [CIW-1:0] csr_index;
   logic [CDW-1:0] csr_write_data;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int ready_hold = 0;
   bit sink_calm = 1'b0;
   bit src_calm = 1'b0;
   int word_count = 0;

   bit            loaded    [WEIGHT_COUNT];
   bit [1:0]      grad_dir  [WEIGHT_COUNT];
   logic [IW-1:0] hot_index [HOT_COUNT];

   rprop_req_if req_bus ();
   rprop_rsp_if rsp_bus ();

   rprop_weight_update_core #(
      .WEIGHT_COUNT(WEIGHT_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rprop_weight_update_checker #(
      .WEIGHT_COUNT(WEIGHT_COUNT)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int next_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            ready_hold <= next_gap(sink_calm);
      end
      if ($urandom_range(0, 199) == 0)
         sink_calm <= ~sink_calm;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic act, input logic [IW-1:0] idx,
                            input logic [DW-1:0] val);
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.weight_index <= idx;
      req_bus.value <= val;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (act == rprop_pkg::ACT_LOAD) begin
         loaded[idx] = 1'b1;
         grad_dir[idx] = rprop_pkg::SIGN_ZERO;
      end
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic paced_word(input logic act, input logic [IW-1:0] idx,
                             input logic [DW-1:0] val);
      send_word(act, idx, val);
      idle_gap(next_gap(src_calm));
   endtask

   // wait until every result word is back and the pipe has gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CDW-1:0] e_inc,
                             input logic [CDW-1:0] e_dec,
                             input logic [CDW-1:0] s_max,
                             input logic [CDW-1:0] s_min,
                             input logic [CDW-1:0] s_init);
      settle();
      write_reg(rprop_pkg::CSR_ETA_INCREASE, e_inc);
      write_reg(rprop_pkg::CSR_ETA_DECREASE, e_dec);
      write_reg(rprop_pkg::CSR_STEP_MAX, s_max);
      write_reg(rprop_pkg::CSR_STEP_MIN, s_min);
      write_reg(rprop_pkg::CSR_INITIAL_STEP, s_init);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [DW-1:0] load_value();
      logic [DW-1:0] v;
      case ($urandom_range(0, 9))
         0: return {1'b0, {(DW-1){1'b1}}};
         1: return {1'b1, {(DW-1){1'b0}}};
         2, 3, 4: begin
            v = $urandom_range(0, 1 << 27);
            return ($urandom_range(0, 1) == 0) ? -v : v;
         end
         default: return $urandom();
      endcase
   endfunction

   // gradients run in streaks of one sign with flips and zeros mixed in
   function automatic logic [DW-1:0] gradient_for(input logic [IW-1:0] idx);
      logic [1:0]    dir;
      logic [DW-1:0] mag;
      logic [DW-1:0] v;
      int            r;
      dir = grad_dir[idx];
      r = $urandom_range(0, 99);
      if (r >= 92)
         dir = rprop_pkg::SIGN_ZERO;
      else if (dir == rprop_pkg::SIGN_ZERO || r >= 80)
         dir = ($urandom_range(0, 1) == 0) ? rprop_pkg::SIGN_POS : rprop_pkg::SIGN_NEG;
      else if (r >= 55)
         dir = (dir == rprop_pkg::SIGN_POS) ? rprop_pkg::SIGN_NEG : rprop_pkg::SIGN_POS;
      grad_dir[idx] = dir;
      mag = $urandom();
      case ($urandom_range(0, 9))
         0, 1: mag = $urandom_range(1, 255);
         2: mag = '1;
         3: mag = '0;
         default: ;
      endcase
      if (dir == rprop_pkg::SIGN_ZERO)
         return '0;
      if (dir == rprop_pkg::SIGN_NEG)
         return {1'b1, mag[DW-2:0]};
      v = {1'b0, mag[DW-2:0]};
      return (v == '0) ? DW'(1) : v;
   endfunction

   task automatic random_word();
      logic [IW-1:0] idx;
      if ($urandom_range(0, 9) < 8)
         idx = hot_index[$urandom_range(0, HOT_COUNT - 1)];
      else
         idx = IW'($urandom_range(0, WEIGHT_COUNT - 1));
      // an entry is only ever updated after a load
      if (!loaded[idx] || $urandom_range(0, 99) < 12)
         paced_word(rprop_pkg::ACT_LOAD, idx, load_value());
      else
         paced_word(rprop_pkg::ACT_UPDATE, idx, gradient_for(idx));
      word_count++;
      if (word_count % 40 == 0)
         src_calm = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      logic [CDW-1:0] e_inc;
      logic [CDW-1:0] e_dec;
      logic [CDW-1:0] s_max;
      logic [CDW-1:0] s_min;
      logic [CDW-1:0] s_init;
      req_bus.valid = 1'b0;
      req_bus.action = rprop_pkg::ACT_LOAD;
      req_bus.weight_index = '0;
      req_bus.value = '0;
      csr_write_enable = 1'b0;
      csr_index = rprop_pkg::CSR_ETA_INCREASE;
      csr_write_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset settings
      paced_word(rprop_pkg::ACT_LOAD, 10'd0, 32'h7FFF_FFFF);
      paced_word(rprop_pkg::ACT_LOAD, 10'd1023, 32'h8000_0000);
      paced_word(rprop_pkg::ACT_LOAD, 10'd5, 32'h0000_0000);
      paced_word(rprop_pkg::ACT_LOAD, 10'd6, 32'h0000_0001);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd0, 32'hFFFF_FFFF);     // fresh move clips high
      paced_word(rprop_pkg::ACT_UPDATE, 10'd0, 32'h8000_0000);     // same sign, grown step
      paced_word(rprop_pkg::ACT_UPDATE, 10'd0, 32'h7FFF_FFFF);     // flip backs out the move
      paced_word(rprop_pkg::ACT_UPDATE, 10'd0, 32'h0000_0000);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd1023, 32'h0000_0001);  // fresh move clips low
      paced_word(rprop_pkg::ACT_UPDATE, 10'd1023, 32'h1234_5678);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd1023, 32'h0000_0000);  // zero after a stored sign
      paced_word(rprop_pkg::ACT_UPDATE, 10'd1023, 32'h1234_5678);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'h0000_0001);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'h0000_0100);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'hFFFF_FFFF);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'hFFFF_FFFF);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'hFFFF_FFF0);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'h4000_0000);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd6, 32'h0000_0000);
      paced_word(rprop_pkg::ACT_LOAD, 10'd5, 32'h5555_5555);       // reload clears history
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'hAAAA_AAAA);
      paced_word(rprop_pkg::ACT_UPDATE, 10'd5, 32'hAAAA_AAAA);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1: begin
               e_inc = '0;
               e_dec = '0;
               s_max = '0;
               s_min = '0;
               s_init = '0;
            end
            2: begin
               e_inc = CDW'({EW{1'b1}});
               e_dec = CDW'({EW{1'b1}});
               s_max = rprop_pkg::STEP_LIMIT;
               s_min = rprop_pkg::STEP_LIMIT;
               s_init = rprop_pkg::STEP_LIMIT;
            end
            4: begin
               // raw words, upper bits of the eta registers included
               e_inc = CDW'($urandom());
               e_dec = CDW'($urandom());
               s_max = CDW'($urandom());
               s_min = CDW'($urandom());
               s_init = CDW'($urandom());
            end
            5: begin
               e_inc = CDW'(rprop_pkg::ETA_INCREASE_RESET);
               e_dec = CDW'(rprop_pkg::ETA_DECREASE_RESET);
               s_max = rprop_pkg::STEP_MAX_RESET;
               s_min = rprop_pkg::STEP_MIN_RESET;
               s_init = rprop_pkg::INITIAL_STEP_RESET;
            end
            default: begin
               e_inc = CDW'($urandom_range(65536, 131072));
               e_dec = CDW'($urandom_range(0, 65536));
               s_max = CDW'($urandom_range(1 << 20, 1 << 30));
               s_min = CDW'($urandom_range(0, 1 << 16));
               s_init = CDW'($urandom_range(1 << 12, 1 << 26));
            end
         endcase
         set_config(e_inc, e_dec, s_max, s_min, s_init);
         for (int h = 0; h < HOT_COUNT; h++)
            hot_index[h] = IW'($urandom_range(0, WEIGHT_COUNT - 1));
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            random_word();
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/rprop_pkg.sv
hdl/rprop_if.sv
hdl/rprop_ctrl.sv
hdl/rprop_dpath.sv
hdl/rprop_weight_update_core.sv
hdl/rprop_checker.sv
verif/rprop_weight_update_checker.sv
verif/rprop_weight_update_core_test.sv
